// ===== sv/ist_pkg.sv =====
`timescale 1ns / 1ps

package ist_pkg;

    // table geometry
    localparam int DEPTH       = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    // request field widths
    localparam int TYPE_W = 3;
    localparam int POS_W  = 8;
    localparam int CAP_W  = 9;

    // request types
    localparam logic [TYPE_W-1:0] OP_INSERT_AT     = 3'd0;
    localparam logic [TYPE_W-1:0] OP_INSERT_SORTED = 3'd1;
    localparam logic [TYPE_W-1:0] OP_ERASE_AT      = 3'd2;
    localparam logic [TYPE_W-1:0] OP_REMOVE_VALUE  = 3'd3;
    localparam logic [TYPE_W-1:0] OP_READ_AT       = 3'd4;
    localparam logic [TYPE_W-1:0] OP_WRITE_AT      = 3'd5;
    localparam logic [TYPE_W-1:0] OP_FIND_VALUE    = 3'd6;

    // register map
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

    // stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

endpackage

// ===== sv/indexed_sequence_table_unit.sv =====
`timescale 1ns / 1ps

// Packed, ordered table of up to 256 32-bit values held in a single-port-write,
// registered-read memory. One request is taken at a time; s_tready is low while
// it is worked. Every memory access presents the address and then uses the registered
// data, and a small sequencer walks the table one entry per access: read and
// write touch a single entry, a positional insert or erase shifts the entries
// past the position, a sorted insert scans for its place and then shifts the
// entries above it, and remove and find visit the entries in turn.
// A finished result waits in an output register, so the next request is taken
// while it is still pending.
// No clearing pass after reset: only entries below the fill level are ever read.
module indexed_sequence_table_unit
    import ist_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position[7:0], item_value[39:8]
    input  logic [TYPE_W-1:0]    s_tuser,   // req_type[2:0]
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // ok[0], index[8:1], read_data[40:9],
                                            // removed_count[49:41], fill_level[58:50],
                                            // is_empty[59], zero[63:60]
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SCAN_RD  = 4'd1;
    localparam logic [3:0] S_SCAN_CMP = 4'd2;
    localparam logic [3:0] S_SHR_RD   = 4'd3;
    localparam logic [3:0] S_SHR_WR   = 4'd4;
    localparam logic [3:0] S_INS_WR   = 4'd5;
    localparam logic [3:0] S_SHL_RD   = 4'd6;
    localparam logic [3:0] S_SHL_WR   = 4'd7;
    localparam logic [3:0] S_RM_RD    = 4'd8;
    localparam logic [3:0] S_RM_CMP   = 4'd9;
    localparam logic [3:0] S_RD_RD    = 4'd10;
    localparam logic [3:0] S_RD_CAP   = 4'd11;
    localparam logic [3:0] S_SET      = 4'd12;
    localparam logic [3:0] S_DONE     = 4'd13;

    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(DEPTH);

    logic [3:0]             state_reg, state_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [CNT_W-1:0]       ptr_reg, ptr_next;
    logic [CNT_W-1:0]       wr_reg, wr_next;
    logic [TYPE_W-1:0]      op_reg, op_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [CAP_W-1:0]       capacity_reg;

    logic                   res_ok_reg, res_ok_next;
    logic [POS_W-1:0]       res_idx_reg, res_idx_next;
    logic [VALUE_WIDTH-1:0] res_rd_reg, res_rd_next;
    logic [CNT_W-1:0]       res_cnt_reg, res_cnt_next;

    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;
    logic                   out_load;

    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rdata_reg;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [ADDR_W-1:0]      mem_raddr;

    logic [POS_W-1:0]       in_pos;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [CNT_W-1:0]       in_pos_w;
    logic [CNT_W-1:0]       limit;
    logic [CNT_W-1:0]       ptr_inc;
    logic [CNT_W-1:0]       ptr_dec;
    logic                   keep;
    logic [CNT_W-1:0]       wr_keep;
    logic                   cfg_write;

    assign in_pos   = s_tdata[7:0];
    assign in_val   = s_tdata[39:8];
    assign in_pos_w = CNT_W'(in_pos);
    assign limit    = (CNT_W'(capacity_reg) > CNT_DEPTH) ? CNT_DEPTH : CNT_W'(capacity_reg);
    assign ptr_inc  = ptr_reg + CNT_ONE;
    assign ptr_dec  = ptr_reg - CNT_ONE;
    assign keep     = (rdata_reg != val_reg);
    assign wr_keep  = wr_reg + CNT_W'(keep);

    assign s_tready = (state_reg == S_IDLE);

    // configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
    assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RESET;
        end
        else if (cfg_write)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        ptr_next     = ptr_reg;
        wr_next      = wr_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        res_ok_next  = res_ok_reg;
        res_idx_next = res_idx_reg;
        res_rd_next  = res_rd_reg;
        res_cnt_next = res_cnt_reg;
        mem_we       = 1'b0;
        mem_waddr    = ptr_reg[ADDR_W-1:0];
        mem_wdata    = rdata_reg;
        mem_raddr    = ptr_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next      = s_tuser;
                    pos_next     = in_pos;
                    val_next     = in_val;
                    res_ok_next  = 1'b0;
                    res_idx_next = '0;
                    res_rd_next  = '0;
                    res_cnt_next = '0;
                    ptr_next     = '0;
                    wr_next      = '0;
                    state_next   = S_DONE;
                    unique case (s_tuser)
                        OP_INSERT_AT:
                        begin
                            if (used_reg < limit && in_pos_w <= used_reg)
                            begin
                                ptr_next   = used_reg;
                                state_next = (in_pos_w == used_reg) ? S_INS_WR : S_SHR_RD;
                            end
                        end
                        OP_INSERT_SORTED:
                        begin
                            if (used_reg < limit)
                            begin
                                if (used_reg == '0)
                                begin
                                    pos_next   = '0;
                                    state_next = S_INS_WR;
                                end
                                else
                                begin
                                    state_next = S_SCAN_RD;
                                end
                            end
                        end
                        OP_ERASE_AT:
                        begin
                            if (in_pos_w < used_reg)
                            begin
                                ptr_next = in_pos_w;
                                if (in_pos_w + CNT_ONE == used_reg)
                                begin
                                    used_next   = used_reg - CNT_ONE;
                                    res_ok_next = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_SHL_RD;
                                end
                            end
                        end
                        OP_REMOVE_VALUE:
                        begin
                            if (used_reg != '0)
                            begin
                                state_next = S_RM_RD;
                            end
                        end
                        OP_READ_AT:
                        begin
                            if (in_pos_w < used_reg)
                            begin
                                state_next = S_RD_RD;
                            end
                        end
                        OP_WRITE_AT:
                        begin
                            if (in_pos_w < used_reg)
                            begin
                                state_next = S_SET;
                            end
                        end
                        OP_FIND_VALUE:
                        begin
                            if (used_reg != '0)
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end

            // find: first equal entry; sorted insert: first entry above the value
            S_SCAN_CMP:
            begin
                if (op_reg == OP_FIND_VALUE)
                begin
                    if (rdata_reg == val_reg)
                    begin
                        res_ok_next  = 1'b1;
                        res_idx_next = ptr_reg[POS_W-1:0];
                        state_next   = S_DONE;
                    end
                    else if (ptr_inc == used_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_SCAN_RD;
                    end
                end
                else if (rdata_reg <= val_reg)
                begin
                    if (ptr_inc == used_reg)
                    begin
                        pos_next   = ptr_inc[POS_W-1:0];
                        ptr_next   = used_reg;
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        ptr_next   = ptr_inc;
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    pos_next   = ptr_reg[POS_W-1:0];
                    ptr_next   = used_reg;
                    state_next = S_SHR_RD;
                end
            end

            // open a gap: move entry ptr-1 up to ptr
            S_SHR_RD:
            begin
                mem_raddr  = ptr_dec[ADDR_W-1:0];
                state_next = S_SHR_WR;
            end

            S_SHR_WR:
            begin
                mem_we     = 1'b1;
                ptr_next   = ptr_dec;
                state_next = (ptr_dec == CNT_W'(pos_reg)) ? S_INS_WR : S_SHR_RD;
            end

            S_INS_WR:
            begin
                mem_we      = 1'b1;
                mem_waddr   = pos_reg[ADDR_W-1:0];
                mem_wdata   = val_reg;
                used_next   = used_reg + CNT_ONE;
                res_ok_next = 1'b1;
                if (op_reg == OP_INSERT_SORTED)
                begin
                    res_idx_next = pos_reg;
                end
                state_next = S_DONE;
            end

            // close a gap: move entry ptr+1 down to ptr
            S_SHL_RD:
            begin
                mem_raddr  = ptr_inc[ADDR_W-1:0];
                state_next = S_SHL_WR;
            end

            S_SHL_WR:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_inc;
                if (ptr_reg + CNT_TWO == used_reg)
                begin
                    used_next   = used_reg - CNT_ONE;
                    res_ok_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SHL_RD;
                end
            end

            // remove: stable compaction, wr trails ptr
            S_RM_RD:
            begin
                state_next = S_RM_CMP;
            end

            S_RM_CMP:
            begin
                mem_we    = keep;
                mem_waddr = wr_reg[ADDR_W-1:0];
                if (ptr_inc == used_reg)
                begin
                    used_next    = wr_keep;
                    res_cnt_next = used_reg - wr_keep;
                    res_ok_next  = (used_reg != wr_keep);
                    state_next   = S_DONE;
                end
                else
                begin
                    wr_next    = wr_keep;
                    ptr_next   = ptr_inc;
                    state_next = S_RM_RD;
                end
            end

            S_RD_RD:
            begin
                mem_raddr  = pos_reg[ADDR_W-1:0];
                state_next = S_RD_CAP;
            end

            S_RD_CAP:
            begin
                res_rd_next = rdata_reg;
                res_ok_next = 1'b1;
                state_next  = S_DONE;
            end

            S_SET:
            begin
                mem_we      = 1'b1;
                mem_waddr   = pos_reg[ADDR_W-1:0];
                mem_wdata   = val_reg;
                res_ok_next = 1'b1;
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        wr_reg      <= wr_next;
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        res_ok_reg  <= res_ok_next;
        res_idx_reg <= res_idx_next;
        res_rd_reg  <= res_rd_next;
        res_cnt_reg <= res_cnt_next;
    end

    // result register
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {4'd0, (used_reg == '0), used_reg, res_cnt_reg,
                             res_rd_reg, res_idx_reg, res_ok_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_DEPTH)
        else $error("fill level above table depth");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_WR |-> used_reg < limit)
        else $error("insert into a full table");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[59] == (m_tdata[58:50] == '0)))
        else $error("empty flag disagrees with fill level");
`endif

endmodule
